@@ hw/rtl/fjot_pkg.sv @@
// ----------------------------------------------------------------------------
// fjot_pkg
// Shared types and constants for the flat JSON object tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package fjot_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_N       = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [6:0] {
        ST_TOP   = 7'b0000001,
        ST_KQ    = 7'b0000010,
        ST_KEY   = 7'b0000100,
        ST_COLON = 7'b0001000,
        ST_VQ    = 7'b0010000,
        ST_VAL   = 7'b0100000,
        ST_SEP   = 7'b1000000
    } t_pstate;

    typedef struct packed {
        logic              valid;
        logic              is_value;
        logic [BYTE_W-1:0] data;
        logic              rec_start;
        logic              pair_done;
        logic              rec_done;
        logic              strm_done;
    } t_result;

    function automatic logic [BYTE_W-1:0] expect_char(input t_pstate s);
        logic [BYTE_W-1:0] c;
        c = '0;
        case (s)
            ST_TOP:   c = CH_OPEN;
            ST_KQ:    c = CH_QUOTE;
            ST_KEY:   c = CH_QUOTE;
            ST_COLON: c = CH_COLON;
            ST_VQ:    c = CH_QUOTE;
            ST_VAL:   c = CH_QUOTE;
            ST_SEP:   c = CH_COMMA;
            default:  c = '0;
        endcase
        return c;
    endfunction

    function automatic t_pstate advance(input t_pstate s);
        t_pstate n;
        n = s;
        case (s)
            ST_TOP:   n = ST_KQ;
            ST_KQ:    n = ST_KEY;
            ST_KEY:   n = ST_COLON;
            ST_COLON: n = ST_VQ;
            ST_VQ:    n = ST_VAL;
            ST_VAL:   n = ST_SEP;
            ST_SEP:   n = ST_KQ;
            default:  n = s;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/flat_json_object_tokenizer.sv @@
// Path: an accepted input beat goes through the input register, then the result register, to the master side.
// Throughput: one beat per cycle unless the master side stalls; the parse state updates on each processed byte.
// Input and output registers decouple the two sides; a stall holds the result register.
// Reset: synchronous, active low; parser returns to expecting an open brace, no record open.
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer
// Byte-stream tokenizer for flat JSON objects with string keys and values.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_json_object_tokenizer
    import fjot_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire logic              s_tlast,   // stream_end
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic [4:0]             m_tuser,   // [0] byte_valid, [1] byte_is_value,
                                              // [2] record_start, [3] pair_done,
                                              // [4] record_done
    output logic                   m_tlast    // stream_done
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_res;
    logic              step;

    assign step     = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_data <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    fjot_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_data),
        .i_end   (r_in_last),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out.data;
    assign m_tuser  = {r_out.rec_done, r_out.pair_done, r_out.rec_start,
                       r_out.is_value, r_out.valid};
    assign m_tlast  = r_out.strm_done;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_tready |-> !step)
        else $error("result overwritten while stalled");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed beat lost");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in_data) && $stable(r_in_last))
        else $error("pending input beat dropped");

endmodule

`default_nettype wire

@@ hw/rtl/fjot_parse.sv @@
// ----------------------------------------------------------------------------
// fjot_parse
// Parse state tracker: per-byte delimiter match, escape handling and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module fjot_parse
    import fjot_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_end,
    output t_result                o_res
);

    t_pstate r_state, n_state;
    logic    r_esc, n_esc;
    logic    r_key_ne, n_key_ne;
    logic    r_rec_open, n_rec_open;

    logic              is_sep;
    logic              match;
    logic [BYTE_W-1:0] c_esc;

    always_comb begin
        n_state    = r_state;
        n_esc      = r_esc;
        n_key_ne   = r_key_ne;
        n_rec_open = r_rec_open;
        o_res      = '0;
        is_sep     = (r_state == ST_SEP);
        match      = (i_byte == expect_char(r_state)) && !r_esc;
        c_esc      = (r_esc && i_byte == CH_N) ? CH_NEWLINE : i_byte;

        if (i_end) begin
            o_res.strm_done = 1'b1;
        end else begin
            n_rec_open = 1'b1;
            if (!r_rec_open) begin
                o_res.rec_start = 1'b1;
            end
            if (is_sep && r_key_ne) begin
                o_res.pair_done = 1'b1;
                n_key_ne        = 1'b0;
            end
            if (is_sep && i_byte == CH_CLOSE) begin
                o_res.rec_done = 1'b1;
                n_rec_open     = 1'b0;
            end
            if (match) begin
                n_state = advance(r_state);
            end else if (c_esc == CH_BSLASH) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (r_state == ST_KEY) begin
                    o_res.valid = 1'b1;
                    o_res.data  = c_esc;
                    n_key_ne    = 1'b1;
                end else if (r_state == ST_VAL) begin
                    o_res.valid    = 1'b1;
                    o_res.is_value = 1'b1;
                    o_res.data     = c_esc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_TOP;
            r_esc      <= 1'b0;
            r_key_ne   <= 1'b0;
            r_rec_open <= 1'b0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_esc      <= n_esc;
            r_key_ne   <= n_key_ne;
            r_rec_open <= n_rec_open;
        end
    end

    a_pair_clears_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.pair_done |=> !r_key_ne)
        else $error("key flag not cleared after pair");

    a_key_byte_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid && !o_res.is_value |=> r_key_ne)
        else $error("key flag not set after key byte");

    a_rec_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.rec_done |=> !r_rec_open && r_state == ST_SEP)
        else $error("record not closed after close brace");

    a_end_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_end |=> $stable(r_state) && $stable(r_esc) && $stable(r_rec_open))
        else $error("state changed on end-of-stream beat");

endmodule

`default_nettype wire
